### src/arm_instruction_class_decoder_macros.svh
// Assertion macros for the ARM instruction class decoder.
// Properties are sampled on clk_i and disabled while rst_ni is low.
// Users must have clk_i and rst_ni in scope.
`ifndef ARM_INSTRUCTION_CLASS_DECODER_MACROS_SVH
`define ARM_INSTRUCTION_CLASS_DECODER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property on every rising clock edge outside reset
`define AICD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition never holds outside reset
`define AICD_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define AICD_ASSERT(lbl, prop, msg)
`define AICD_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

### src/aicd_pkg.sv
// Shared types and codes for the ARM instruction class decoder.
// No dependencies; used by aicd_decode and arm_instruction_class_decoder.
package aicd_pkg;

  localparam int unsigned WordWidth  = 32;
  localparam int unsigned ClassWidth = 4;

  // Instruction class codes
  typedef enum logic [ClassWidth-1:0] {
    CLS_DATAPROC = 4'd0,
    CLS_PSR      = 4'd1,
    CLS_BX       = 4'd2,
    CLS_MUL      = 4'd3,
    CLS_MULL     = 4'd4,
    CLS_SWAP     = 4'd5,
    CLS_HALF     = 4'd6,
    CLS_SINGLE   = 4'd7,
    CLS_BRANCH   = 4'd8,
    CLS_BLOCK    = 4'd9,
    CLS_SWI      = 4'd10,
    CLS_UNDEF    = 4'd11
  } class_e;

  // Decoded control bits for one instruction
  typedef struct packed {
    class_e      instr_class;
    logic        immediate;
    logic [3:0]  alu_opcode;
    logic [3:0]  shift_bits;
    logic        update_flags;
    logic        pre_or_link;
    logic        up_add;
    logic        write_back;
    logic        load;
    logic        variant_bit;
    logic        accum_or_to_psr;
    logic [1:0]  halfword_kind;
  } decode_t;

endpackage

### src/arm_instruction_class_decoder.sv
// ARM-state instruction class decoder: input register, decode, result register.
// The word is registered, decoded, and its result registered; out_stall_i holds the result.
// Throughput: one item per cycle when not stalled, set by the single decode pass.
// Reset (rst_ni low, asynchronous) empties both stages; payload is not cleared.
// Depends on aicd_pkg, aicd_decode and arm_instruction_class_decoder_macros.svh.
`include "arm_instruction_class_decoder_macros.svh"
module arm_instruction_class_decoder
  import aicd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [WordWidth-1:0]  instruction_word_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [ClassWidth-1:0] instr_class_o,
  output logic                  immediate_o,
  output logic [3:0]            alu_opcode_o,
  output logic [3:0]            shift_bits_o,
  output logic                  update_flags_o,
  output logic                  pre_or_link_o,
  output logic                  up_add_o,
  output logic                  write_back_o,
  output logic                  load_o,
  output logic                  variant_bit_o,
  output logic                  accum_or_to_psr_o,
  output logic [1:0]            halfword_kind_o
);

  logic                 s1_valid_q;
  logic [WordWidth-1:0] s1_word_q;
  logic                 out_valid_q;
  decode_t              out_q;
  decode_t              dec;
  logic                 out_adv;
  logic                 s1_adv;
  logic                 both_full_held;
  logic                 no_field_class;
  logic                 any_field_set;

  // Stage moves when it is empty or the stage after it moves
  assign out_adv    = !out_valid_q || !out_stall_i;
  assign s1_adv     = !s1_valid_q || out_adv;
  assign in_stall_o = !s1_adv;

  aicd_decode u_decode (
    .word_i (s1_word_q),
    .dec_o  (dec)
  );

  // Hold stage valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Capture payload on each transfer into a stage
  always_ff @(posedge clk_i) begin
    if (s1_adv && in_valid_i) begin
      s1_word_q <= instruction_word_i;
    end
    if (out_adv && s1_valid_q) begin
      out_q <= dec;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign instr_class_o     = out_q.instr_class;
  assign immediate_o       = out_q.immediate;
  assign alu_opcode_o      = out_q.alu_opcode;
  assign shift_bits_o      = out_q.shift_bits;
  assign update_flags_o    = out_q.update_flags;
  assign pre_or_link_o     = out_q.pre_or_link;
  assign up_add_o          = out_q.up_add;
  assign write_back_o      = out_q.write_back;
  assign load_o            = out_q.load;
  assign variant_bit_o     = out_q.variant_bit;
  assign accum_or_to_psr_o = out_q.accum_or_to_psr;
  assign halfword_kind_o   = out_q.halfword_kind;

  // Conditions used by the checks below
  assign both_full_held = s1_valid_q && out_valid_q && out_stall_i;
  assign no_field_class = (instr_class_o == CLS_BX) || (instr_class_o == CLS_SWI) ||
                          (instr_class_o == CLS_UNDEF);
  assign any_field_set  = immediate_o || update_flags_o || pre_or_link_o || load_o ||
                          variant_bit_o || accum_or_to_psr_o || (alu_opcode_o != 4'd0) ||
                          (halfword_kind_o != 2'd0);

  // An accepted transfer always lands in the input stage
  `AICD_ASSERT(a_in_lands, (in_valid_i && !in_stall_o) |=> s1_valid_q, "input transfer lost")

  // Stall only when both stages are full and the result is held
  `AICD_ASSERT_NEVER(a_stall_full, in_stall_o && !both_full_held, "stall with free space")

  // Classes without fields carry all-zero control bits
  `AICD_ASSERT_NEVER(a_empty_fields, out_valid_o && no_field_class && any_field_set, "fields set")

endmodule

### src/aicd_decode.sv
// Combinational class decode of one ARM-state instruction word.
// Depends on aicd_pkg for the class codes and the decode_t result.
module aicd_decode
  import aicd_pkg::*;
(
  input  logic [WordWidth-1:0] word_i,
  output decode_t              dec_o
);

  // Encoding fragments in bits 27:20 and 7:4
  localparam logic [7:0] BxOpcode   = 8'b0001_0010;
  localparam logic [3:0] BxNibble   = 4'b0001;
  localparam logic [3:0] MulNibble  = 4'b1001;
  localparam logic [3:0] HalfNibble = 4'b1011;
  localparam logic [1:0] GrpArith   = 2'b00;
  localparam logic [1:0] GrpSingle  = 2'b01;
  localparam logic [1:0] GrpBranch  = 2'b10;
  localparam logic [1:0] GrpCoproc  = 2'b11;

  logic    dp_sel;
  logic    dp_imm;
  logic    is_bx;
  logic    is_half;
  decode_t res;

  assign is_bx   = (word_i[27:20] == BxOpcode) && (word_i[7:4] == BxNibble);
  assign is_half = (word_i[7:4] == HalfNibble) || (word_i[7] && word_i[6] && word_i[4]);

  // Sort the word into its class and copy out the applicable bits
  always_comb begin
    res    = '0;
    dp_sel = 1'b0;
    dp_imm = 1'b0;
    unique case (word_i[27:26])
      GrpArith: begin
        if (word_i[25]) begin
          dp_sel = 1'b1;
          dp_imm = 1'b1;
        end else if (is_bx) begin
          res.instr_class = CLS_BX;
        end else if (!word_i[24] && (word_i[7:4] == MulNibble)) begin
          res.accum_or_to_psr = word_i[21];
          res.update_flags    = word_i[20];
          if (word_i[23]) begin
            res.instr_class = CLS_MULL;
            res.variant_bit = word_i[22];
          end else begin
            res.instr_class = CLS_MUL;
          end
        end else if (word_i[24] && (word_i[7:4] == MulNibble)) begin
          res.instr_class = CLS_SWAP;
          res.variant_bit = word_i[22];
        end else if (is_half) begin
          res.instr_class   = CLS_HALF;
          res.immediate     = word_i[22];
          res.pre_or_link   = word_i[24];
          res.up_add        = word_i[23];
          res.write_back    = word_i[21];
          res.load          = word_i[20];
          res.halfword_kind = word_i[6:5];
        end else begin
          dp_sel = 1'b1;
        end
      end
      GrpSingle: begin
        // register offset with bit 4 set is undefined
        if (word_i[25] && word_i[4]) begin
          res.instr_class = CLS_UNDEF;
        end else begin
          res.instr_class = CLS_SINGLE;
          res.immediate   = ~word_i[25];
          res.variant_bit = word_i[22];
          res.pre_or_link = word_i[24];
          res.up_add      = word_i[23];
          res.write_back  = word_i[21];
          res.load        = word_i[20];
        end
      end
      GrpBranch: begin
        if (word_i[25]) begin
          res.instr_class = CLS_BRANCH;
          res.pre_or_link = word_i[24];
        end else begin
          res.instr_class = CLS_BLOCK;
          res.variant_bit = word_i[22];
          res.pre_or_link = word_i[24];
          res.up_add      = word_i[23];
          res.write_back  = word_i[21];
          res.load        = word_i[20];
        end
      end
      GrpCoproc: begin
        // coprocessor space decodes as undefined
        if (word_i[25] && word_i[24]) begin
          res.instr_class = CLS_SWI;
        end else begin
          res.instr_class = CLS_UNDEF;
        end
      end
      default: begin
        res.instr_class = CLS_UNDEF;
      end
    endcase

    // Data processing, or status transfer for test/compare opcodes without S
    if (dp_sel) begin
      res.immediate = dp_imm;
      if (!word_i[20] && (word_i[24:23] == 2'b10)) begin
        res.instr_class     = CLS_PSR;
        res.variant_bit     = word_i[22];
        res.accum_or_to_psr = word_i[21];
      end else begin
        res.instr_class  = CLS_DATAPROC;
        res.alu_opcode   = word_i[24:21];
        res.update_flags = word_i[20];
        res.shift_bits   = dp_imm ? 4'b0000 : word_i[7:4];
      end
    end
  end

  assign dec_o = res;

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for arm_instruction_class_decoder: directed table plus biased random words.
// Every decode is checked field by field, against the fixed class of its row or an in-bench class predictor.
// Depends on aicd_pkg and the decoder RTL.
module tb
  import aicd_pkg::*;
();

  localparam int unsigned NumDirected = 25;
  localparam int unsigned IdleLimit   = 1000;
  localparam int unsigned LongHold    = 200;
  localparam int unsigned MaxReports  = 60;

  // One row of the directed table; cls is the expected class of a fixed row, whose
  // other fields are all zero. Rows without fixed go through the predictor.
  typedef struct packed {
    logic [31:0] word;
    logic        fixed;
    class_e      cls;
  } table_row_t;

  typedef struct packed {
    logic [31:0] word;
    decode_t     want;
  } pending_t;

  localparam table_row_t DirectedRows [NumDirected] = '{
    '{32'h0000_0000, 1'b1, CLS_DATAPROC},  // all zero: AND r0, r0, r0
    '{32'hF000_0000, 1'b1, CLS_DATAPROC},  // condition bits alone change nothing
    '{32'hFFFF_FFFF, 1'b1, CLS_SWI},
    '{32'hEF00_0000, 1'b1, CLS_SWI},
    '{32'hEE00_0010, 1'b1, CLS_UNDEF},     // coprocessor register transfer
    '{32'h0C00_0000, 1'b1, CLS_UNDEF},     // coprocessor data transfer
    '{32'hE7F0_00F0, 1'b1, CLS_UNDEF},     // register-offset transfer with bit 4 set
    '{32'hE12F_FF1E, 1'b1, CLS_BX},
    '{32'hE120_0031, 1'b0, CLS_UNDEF},     // near miss of bx: status transfer
    '{32'hE091_2113, 1'b0, CLS_UNDEF},     // adds with register shift
    '{32'hE3A0_00FF, 1'b0, CLS_UNDEF},     // mov immediate, shift bits hidden
    '{32'hE10F_0000, 1'b0, CLS_UNDEF},     // read status
    '{32'hE368_F00F, 1'b0, CLS_UNDEF},     // write saved status, immediate
    '{32'hE170_0000, 1'b0, CLS_UNDEF},     // compare with flags set stays dataproc
    '{32'hE031_0392, 1'b0, CLS_UNDEF},     // multiply accumulate, flags
    '{32'hE0F1_0392, 1'b0, CLS_UNDEF},     // signed long multiply accumulate
    '{32'hE141_0092, 1'b0, CLS_UNDEF},     // byte swap
    '{32'hE1D0_00B0, 1'b0, CLS_UNDEF},     // load halfword, immediate offset
    '{32'hE150_00D0, 1'b0, CLS_UNDEF},     // load signed byte
    '{32'hE020_00F0, 1'b0, CLS_UNDEF},     // kind 3, write-back, register offset
    '{32'hE7C0_0000, 1'b0, CLS_UNDEF},     // store byte, register offset
    '{32'hE4B0_0004, 1'b0, CLS_UNDEF},     // load, post-index, write-back
    '{32'hEBFF_FFFF, 1'b0, CLS_UNDEF},     // branch with link
    '{32'h0A00_0000, 1'b0, CLS_UNDEF},     // plain branch
    '{32'hE9D0_000F, 1'b0, CLS_UNDEF}      // block load, user bank, no write-back
  };

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [WordWidth-1:0]  word;
  logic                  out_valid;
  logic                  out_stall;
  logic [ClassWidth-1:0] instr_class;
  logic                  immediate;
  logic [3:0]            alu_opcode;
  logic [3:0]            shift_bits;
  logic                  update_flags;
  logic                  pre_or_link;
  logic                  up_add;
  logic                  write_back;
  logic                  load;
  logic                  variant_bit;
  logic                  accum_or_to_psr;
  logic [1:0]            halfword_kind;

  // Transfer flags, sampled mid-cycle and consumed at the following rising edge
  bit          in_take;
  bit          out_take;
  bit          calm;
  bit          long_hold;
  bit          row_fixed;
  decode_t     fixed_decode;
  pending_t    decodes_due [$];
  int unsigned errors;
  int unsigned words_taken;
  int unsigned results_seen;
  int unsigned idle_cycles;
  bit [11:0]   classes_seen;

  arm_instruction_class_decoder dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .instruction_word_i (word),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .instr_class_o      (instr_class),
    .immediate_o        (immediate),
    .alu_opcode_o       (alu_opcode),
    .shift_bits_o       (shift_bits),
    .update_flags_o     (update_flags),
    .pre_or_link_o      (pre_or_link),
    .up_add_o           (up_add),
    .write_back_o       (write_back),
    .load_o             (load),
    .variant_bit_o      (variant_bit),
    .accum_or_to_psr_o  (accum_or_to_psr),
    .halfword_kind_o    (halfword_kind)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Data processing versus status transfer; opcodes 8 to 11 without S go to status
  function automatic decode_t alu_or_status(logic [31:0] w, logic imm);
    decode_t d;
    d = '0;
    d.immediate = imm;
    if (!w[20] && w[24:23] == 2'b10) begin
      d.instr_class     = CLS_PSR;
      d.variant_bit     = w[22];
      d.accum_or_to_psr = w[21];
    end else begin
      d.instr_class  = CLS_DATAPROC;
      d.alu_opcode   = w[24:21];
      d.update_flags = w[20];
      d.shift_bits   = imm ? 4'h0 : w[7:4];
    end
    return d;
  endfunction

  // Copy the addressing bits shared by the halfword, single and block transfer classes
  function automatic decode_t with_addressing(decode_t d, logic [31:0] w);
    d.pre_or_link = w[24];
    d.up_add      = w[23];
    d.write_back  = w[21];
    d.load        = w[20];
    return d;
  endfunction

  // Predict the decode of one instruction word
  function automatic decode_t decode_word(logic [31:0] w);
    decode_t d;
    d = '0;
    case (w[27:26])
      2'b00: begin
        if (w[25]) begin
          d = alu_or_status(w, 1'b1);
        end else if (w[27:20] == 8'h12 && w[7:4] == 4'h1) begin
          d.instr_class = CLS_BX;
        end else if (!w[24] && w[7:4] == 4'h9) begin
          d.accum_or_to_psr = w[21];
          d.update_flags    = w[20];
          if (w[23]) begin
            d.instr_class = CLS_MULL;
            d.variant_bit = w[22];
          end else begin
            d.instr_class = CLS_MUL;
          end
        end else if (w[24] && w[7:4] == 4'h9) begin
          d.instr_class = CLS_SWAP;
          d.variant_bit = w[22];
        end else if (w[7:4] == 4'hB || (w[7] && w[6] && w[4])) begin
          d.instr_class   = CLS_HALF;
          d.immediate     = w[22];
          d.halfword_kind = w[6:5];
          d = with_addressing(d, w);
        end else begin
          d = alu_or_status(w, 1'b0);
        end
      end
      2'b01: begin
        if (w[25] && w[4]) begin
          d.instr_class = CLS_UNDEF;
        end else begin
          d.instr_class = CLS_SINGLE;
          d.immediate   = ~w[25];
          d.variant_bit = w[22];
          d = with_addressing(d, w);
        end
      end
      2'b10: begin
        if (w[25]) begin
          d.instr_class = CLS_BRANCH;
          d.pre_or_link = w[24];
        end else begin
          d.instr_class = CLS_BLOCK;
          d.variant_bit = w[22];
          d = with_addressing(d, w);
        end
      end
      default: begin
        d.instr_class = (w[25] && w[24]) ? CLS_SWI : CLS_UNDEF;
      end
    endcase
    return d;
  endfunction

  // Random word, mostly aimed at one class space, content random otherwise
  function automatic logic [31:0] random_word();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 11))
      1: begin
        r[27:25] = 3'b000;
        r[4]     = 1'b0;
      end
      2: begin
        r[27:25] = 3'b000;
        r[7]     = 1'b0;
        r[4]     = 1'b1;
      end
      3: r[27:25] = 3'b001;
      4: begin
        r[27:23] = 5'b00010;
        r[20]    = 1'b0;
      end
      5: begin
        r[27:20] = 8'h12;
        r[7:4]   = 4'h1;
      end
      6: begin
        r[27:24] = 4'h0;
        r[7:4]   = 4'h9;
      end
      7: begin
        r[27:24] = 4'h1;
        r[7:4]   = 4'h9;
      end
      8: begin
        r[27:25] = 3'b000;
        r[7]     = 1'b1;
        r[4]     = 1'b1;
        if (r[6:5] == 2'b00) r[6:5] = 2'($urandom_range(1, 3));
      end
      9:  r[27:26] = 2'b01;
      10: r[27:26] = 2'b10;
      11: r[27:26] = 2'b11;
      default: ;
    endcase
    return r;
  endfunction

  task automatic compare_field(input string field, input logic [31:0] w,
                               input logic [3:0] want, input logic [3:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= MaxReports)
        $display("%0t: word %h %s expected %0h actual %0h", $time, w, field, want, got);
    end
  endtask

  // Compare one result transfer with the oldest pending decode
  task automatic check_decode();
    pending_t head;
    decode_t  got;
    results_seen++;
    got = {instr_class, immediate, alu_opcode, shift_bits, update_flags, pre_or_link, up_add,
           write_back, load, variant_bit, accum_or_to_psr, halfword_kind};
    if (decodes_due.size() == 0) begin
      errors++;
      $display("%0t: result with nothing pending, expected none actual class %0h",
               $time, instr_class);
      return;
    end
    head = decodes_due.pop_front();
    classes_seen[head.want.instr_class] = 1'b1;
    compare_field("instr_class", head.word, head.want.instr_class, got.instr_class);
    compare_field("immediate", head.word, 4'(head.want.immediate), 4'(got.immediate));
    compare_field("alu_opcode", head.word, head.want.alu_opcode, got.alu_opcode);
    compare_field("shift_bits", head.word, head.want.shift_bits, got.shift_bits);
    compare_field("update_flags", head.word, 4'(head.want.update_flags),
                  4'(got.update_flags));
    compare_field("pre_or_link", head.word, 4'(head.want.pre_or_link), 4'(got.pre_or_link));
    compare_field("up_add", head.word, 4'(head.want.up_add), 4'(got.up_add));
    compare_field("write_back", head.word, 4'(head.want.write_back), 4'(got.write_back));
    compare_field("load", head.word, 4'(head.want.load), 4'(got.load));
    compare_field("variant_bit", head.word, 4'(head.want.variant_bit), 4'(got.variant_bit));
    compare_field("accum_or_to_psr", head.word, 4'(head.want.accum_or_to_psr),
                  4'(got.accum_or_to_psr));
    compare_field("halfword_kind", head.word, 4'(head.want.halfword_kind),
                  4'(got.halfword_kind));
  endtask

  // Sample both channels mid-cycle, when nothing is changing
  always @(negedge clk) begin
    in_take  = rst_n && in_valid && !in_stall;
    out_take = rst_n && out_valid && !out_stall;
    if (in_take) begin
      decodes_due.push_back(pending_t'{word, row_fixed ? fixed_decode : decode_word(word)});
      words_taken++;
    end
    if (out_take) check_decode();
  end

  // Abort when no transfer happens for too long
  always @(posedge clk) begin
    if (in_take || out_take) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("%0t: no transfer for %0d cycles, %0d decodes pending",
               $time, idle_cycles, decodes_due.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Offer one word after a random gap (none when calm) and hold it until the transfer
  task automatic send_word(input logic [31:0] w, input logic fixed, input class_e cls);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    word      <= w;
    row_fixed = fixed;
    fixed_decode = '0;
    fixed_decode.instr_class = cls;
    do @(posedge clk); while (!in_take);
  endtask

  // Stop offering and wait until every pending decode has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (decodes_due.size() != 0);
  endtask

  // Result side: stall for a random hold before each result (none when calm), or one long stretch on request
  initial begin : receiver
    int unsigned hold;
    @(posedge rst_n);
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        hold = LongHold;
      end else begin
        hold = calm ? 0 : $urandom_range(0, 14);
      end
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_take);
    end
  end

  initial begin : stimulus
    int unsigned n;
    clk       = 1'b0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    word      = '0;
    out_stall = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed table
    for (n = 0; n < NumDirected; n++)
      send_word(DirectedRows[n].word, DirectedRows[n].fixed, DirectedRows[n].cls);
    wait_drained();

    // Random words with idles on both sides
    for (n = 0; n < 600; n++) send_word(random_word(), 1'b0, CLS_UNDEF);

    // Hold the result side off while words keep coming back to back
    long_hold = 1'b1;
    calm      = 1'b1;
    for (n = 0; n < 40; n++) send_word(random_word(), 1'b0, CLS_UNDEF);
    calm = 1'b0;
    wait_drained();

    // Full-rate stretch with no idles anywhere
    calm = 1'b1;
    for (n = 0; n < 300; n++) send_word(random_word(), 1'b0, CLS_UNDEF);
    calm = 1'b0;
    wait_drained();

    for (n = 0; n < 340; n++) send_word(random_word(), 1'b0, CLS_UNDEF);
    wait_drained();
    repeat (4) @(posedge clk);

    $display("Decoded %0d words (%0d from the table), checked %0d results",
             words_taken, NumDirected, results_seen);
    $display("%0d of 12 classes hit, field mismatches: %0d, decodes left pending: %0d",
             $countones(classes_seen), errors, decodes_due.size());
    if (errors == 0 && decodes_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
